/* rtl/button_press_hold_release_defines.svh */
// assertion macros for the rtl module
`ifndef BUTTON_PRESS_HOLD_RELEASE_DEFINES_SVH
`define BUTTON_PRESS_HOLD_RELEASE_DEFINES_SVH

// checked at every rising clock edge, muted while reset is asserted
`define BPHR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every rising clock edge, also during reset
`define BPHR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/bphr_pkg.sv */
`timescale 1ns / 1ps

package bphr_pkg;

  localparam int NUM_BUTTONS = 6;
  localparam int OUT_FIELDS  = 6;
  localparam int PIN_W       = 8;
  localparam int TICK_W      = 32;
  localparam int DELAY_W     = 16;
  localparam int MASK_W      = PIN_W * OUT_FIELDS;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 64;

  localparam logic [DELAY_W-1:0] HOLD_DELAY_RST    = 16'd1000;
  localparam logic [DELAY_W-1:0] RELEASE_DELAY_RST = 16'd100;
  localparam logic [MASK_W-1:0]  PIN_MASKS_RST     = 48'h2010_0804_0201;

  typedef enum logic [1:0] {
    REG_HOLD_DELAY    = 2'd0,
    REG_RELEASE_DELAY = 2'd1,
    REG_PIN_MASKS     = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_OFF      = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_HELD     = 2'd2,
    ST_RELEASED = 2'd3
  } btn_state_e;

endpackage

/* rtl/button_press_hold_release.sv */
`timescale 1ns / 1ps
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+-------------------------------------------
// input    | in_valid_i   | in_stall_o   | pin_levels_i, now_tick_i
// output   | out_valid_o  | out_stall_i  | up/down/left/right/ok/back_state_o
// config   | psel,penable | pready (=1)  | pwrite, paddr, pwdata, prdata
//
// one item per cycle sustained while the output is not stalled; an item taken in passes
// through the input register, then the result register, before its result shows on the outputs
// the update of all buttons is two 32-bit adds and compares per button, in parallel
// rst_ni clears the button states, saved ticks and valid flags, config registers go to defaults
// a stalled output holds the item in the input register; in_stall_o rises only then

`include "button_press_hold_release_defines.svh"

module button_press_hold_release (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bphr_pkg::PIN_W-1:0]   pin_levels_i,
  input  logic [bphr_pkg::TICK_W-1:0]  now_tick_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   up_state_o,
  output logic [1:0]                   down_state_o,
  output logic [1:0]                   left_state_o,
  output logic [1:0]                   right_state_o,
  output logic [1:0]                   ok_state_o,
  output logic [1:0]                   back_state_o,
  // apb config port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bphr_pkg::ADDR_W-1:0]  paddr,
  input  logic [bphr_pkg::DATA_W-1:0]  pwdata,
  output logic [bphr_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import bphr_pkg::*;

  // ---------------------------------------------------------------- config registers
  logic [DELAY_W-1:0] hold_delay_q;
  logic [DELAY_W-1:0] release_delay_q;
  logic [MASK_W-1:0]  pin_masks_q;
  reg_idx_e           reg_idx;
  logic               cfg_wr;

  // registers sit on 8-byte strides, so the index is the upper address bits
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:3]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_delay_q    <= HOLD_DELAY_RST;
      release_delay_q <= RELEASE_DELAY_RST;
      pin_masks_q     <= PIN_MASKS_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_HOLD_DELAY:    hold_delay_q    <= pwdata[DELAY_W-1:0];
        REG_RELEASE_DELAY: release_delay_q <= pwdata[DELAY_W-1:0];
        REG_PIN_MASKS:     pin_masks_q     <= pwdata[MASK_W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HOLD_DELAY:    prdata = DATA_W'(hold_delay_q);
      REG_RELEASE_DELAY: prdata = DATA_W'(release_delay_q);
      REG_PIN_MASKS:     prdata = DATA_W'(pin_masks_q);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- input register
  logic               s1_valid_q;
  logic [PIN_W-1:0]   pins_q;
  logic [TICK_W-1:0]  now_q;
  logic               s2_load;   // item in the input register moves into the result register
  logic               in_take;

  // the result register frees up when empty or when its item leaves this cycle
  assign s2_load    = s1_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s2_load;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s2_load) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pins_q <= pin_levels_i;
      now_q  <= now_tick_i;
    end
  end

  // ---------------------------------------------------------------- button classifiers
  btn_state_e [NUM_BUTTONS-1:0]             state_q, state_d;
  logic       [NUM_BUTTONS-1:0][TICK_W-1:0] tick_q, tick_d;
  logic       [NUM_BUTTONS-1:0][PIN_W-1:0]  mask;

  // slots past the packed mask word have an empty mask
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_mask
    if (b < OUT_FIELDS) begin : g_cfg
      assign mask[b] = pin_masks_q[PIN_W*b +: PIN_W];
    end else begin : g_zero
      assign mask[b] = '0;
    end
  end

  always_comb begin
    logic              down;
    logic [TICK_W-1:0] hold_end;
    logic [TICK_W-1:0] rel_end;
    state_d = state_q;
    tick_d  = tick_q;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      // a button is down when every pin of its mask reads low (active low pins)
      down     = (pins_q & mask[b]) == '0;
      // deadlines wrap modulo 2^32 before the unsigned compare
      hold_end = tick_q[b] + TICK_W'(hold_delay_q);
      rel_end  = tick_q[b] + TICK_W'(release_delay_q);
      case (state_q[b])
        ST_OFF: begin
          state_d[b] = down ? ST_PRESSED : ST_OFF;
          tick_d[b]  = now_q;
        end
        ST_PRESSED: begin
          // release keeps the press tick as the start of the release delay
          if (!down) begin
            state_d[b] = ST_RELEASED;
          end else if (now_q > hold_end) begin
            state_d[b] = ST_HELD;
          end
        end
        ST_HELD: begin
          state_d[b] = down ? ST_HELD : ST_RELEASED;
          tick_d[b]  = now_q;
        end
        ST_RELEASED: begin
          if (down) begin
            state_d[b] = ST_PRESSED;
            tick_d[b]  = now_q;
          end else if (now_q > rel_end) begin
            state_d[b] = ST_OFF;
          end
        end
        default: begin
          state_d[b] = ST_OFF;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= {NUM_BUTTONS{ST_OFF}};
      tick_q  <= '0;
    end else if (s2_load) begin
      state_q <= state_d;
      tick_q  <= tick_d;
    end
  end

  // ---------------------------------------------------------------- result register
  logic                        out_valid_q;
  logic [OUT_FIELDS-1:0][1:0]  res_d, res_q;

  // fields of buttons that are not built read as off
  for (genvar f = 0; f < OUT_FIELDS; f++) begin : g_res
    if (f < NUM_BUTTONS) begin : g_btn
      assign res_d[f] = state_d[f];
    end else begin : g_none
      assign res_d[f] = 2'(ST_OFF);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign up_state_o    = res_q[0];
  assign down_state_o  = res_q[1];
  assign left_state_o  = res_q[2];
  assign right_state_o = res_q[3];
  assign ok_state_o    = res_q[4];
  assign back_state_o  = res_q[5];

  // ---------------------------------------------------------------- assertions
  `BPHR_ASSERT(a_hold_in_stage, s1_valid_q && out_valid_q && out_stall_i |=> s1_valid_q, "input item lost while output stalled")
  `BPHR_ASSERT(a_load_shows, s2_load |=> out_valid_o && (up_state_o == 2'(state_q[0])), "result does not match updated state")
  `BPHR_ASSERT(a_state_quiet, !s2_load |=> $stable(state_q) && $stable(tick_q), "button state changed without an item")
  `BPHR_ASSERT(a_held_path, (state_q[0] == ST_HELD) && !$stable(state_q[0]) |-> $past(state_q[0]) == ST_PRESSED, "held entered from a state other than pressed")
  `BPHR_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !s1_valid_q && !out_valid_q, "pipeline not empty in reset")

endmodule
